[rtl/core/irc_message_tokenizer_assert.svh]
// Assertion macros for the message tokenizer.
`ifndef IRC_MESSAGE_TOKENIZER_ASSERT_SVH
`define IRC_MESSAGE_TOKENIZER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IRC_TOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a stalled channel keeps valid high and its payload stable.
`define IRC_TOK_HOLD(lbl, vld, rdy, data, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

[rtl/core/irc_tok_pkg.sv]
package irc_tok_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef enum logic [2:0] {
    TAG_SKIP    = 3'd0,
    TAG_NAME    = 3'd1,
    TAG_USER    = 3'd2,
    TAG_HOST    = 3'd3,
    TAG_SEP     = 3'd4,
    TAG_COMMAND = 3'd5,
    TAG_MIDDLE  = 3'd6,
    TAG_TRAIL   = 3'd7
  } tag_t;

  typedef struct packed {
    logic [7:0] out_byte;
    tag_t       field_tag;
    logic       field_start;
    logic [3:0] middle_index;
    logic       too_many_params;
    logic       end_of_message;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_LETTER,
    CLS_SPACE,
    CLS_COLON,
    CLS_BANG,
    CLS_AT
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data_byte;
    logic       last_byte;
  } tok_item_t;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_NAME    = 3'd1,
    PH_USER    = 3'd2,
    PH_HOST    = 3'd3,
    PH_PRESP   = 3'd4,
    PH_COMMAND = 3'd5,
    PH_PARAMS  = 3'd6,
    PH_TRAIL   = 3'd7
  } phase_t;

  localparam logic [7:0] CHR_COLON   = 8'h3A;
  localparam logic [7:0] CHR_BANG    = 8'h21;
  localparam logic [7:0] CHR_AT      = 8'h40;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;

  // Counter value of a three-octet numeric command at its final octet.
  localparam logic [1:0] CMD_NUM_LAST = 2'd2;

  localparam int QUEUE_DEPTH = 2;

endpackage

[rtl/core/irc_message_tokenizer.sv]
// IRC message tokenizer: takes a message line one octet per request, with the
// final octet flagged, and returns each octet tagged with its field (prefix
// name, user, host and separators, command, numbered middle parameters,
// trailing part), a field-start mark and the middle number. It sustains one
// octet per clock cycle in both directions while result_ready stays high;
// an accepted octet is stored in the queue and then in the output register
// before it is offered. The front end classifies each octet as it is
// accepted and places it in a two-entry queue, the back end runs the
// per-octet parse state machine and fills the output register, so input
// and output stall independently. Middle numbers saturate at MAX_MIDDLE-1
// and too_many_params rises once more than MAX_MIDDLE middles have started;
// the parser returns to the start of a message after the flagged final octet.
module irc_message_tokenizer #(
  parameter int MAX_MIDDLE = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  irc_tok_pkg::in_item_t  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output irc_tok_pkg::out_item_t result
);
  import irc_tok_pkg::*;

  tok_item_t front_tok;
  tok_item_t queue_tok;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;

  assign item_ready = !q_full;
  assign q_push     = item_valid && item_ready;

  irc_tok_front u_front (
    .item (item),
    .tok  (front_tok)
  );

  irc_tok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (queue_tok),
    .empty     (q_empty)
  );

  irc_tok_back #(
    .MAX_MIDDLE (MAX_MIDDLE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (!q_empty),
    .tok          (queue_tok),
    .tok_take     (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[rtl/core/irc_tok_front.sv]
module irc_tok_front (
  input  irc_tok_pkg::in_item_t  item,
  output irc_tok_pkg::tok_item_t tok
);
  import irc_tok_pkg::*;

  logic is_letter;

  assign is_letter = ((item.data_byte >= CHR_UPPER_A) && (item.data_byte <= CHR_UPPER_Z)) ||
                     ((item.data_byte >= CHR_LOWER_A) && (item.data_byte <= CHR_LOWER_Z));

  always_comb begin
    tok.data_byte = item.data_byte;
    tok.last_byte = item.last_byte;
    priority if (item.data_byte == CHR_COLON) begin
      tok.cls = CLS_COLON;
    end else if (item.data_byte == CHR_BANG) begin
      tok.cls = CLS_BANG;
    end else if (item.data_byte == CHR_AT) begin
      tok.cls = CLS_AT;
    end else if (item.data_byte == CHR_SPACE) begin
      tok.cls = CLS_SPACE;
    end else if (is_letter) begin
      tok.cls = CLS_LETTER;
    end else begin
      tok.cls = CLS_OTHER;
    end
  end

endmodule

[rtl/core/irc_tok_fifo.sv]
module irc_tok_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  irc_tok_pkg::tok_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output irc_tok_pkg::tok_item_t pop_item,
  output logic                   empty
);
  import irc_tok_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tok_item_t         slot [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/core/irc_tok_back.sv]
module irc_tok_back #(
  parameter int MAX_MIDDLE = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tok_valid,
  input  irc_tok_pkg::tok_item_t tok,
  output logic                   tok_take,
  output logic                   result_valid,
  input  logic                   result_ready,
  output irc_tok_pkg::out_item_t result
);
  import irc_tok_pkg::*;

  localparam int CW = $clog2(MAX_MIDDLE + 2);
  localparam int IW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_MIDDLE);

  phase_t        phase;
  phase_t        phase_next;
  logic [CW-1:0] middle_count;
  logic [CW-1:0] middle_count_next;
  logic [1:0]    numeric_count;
  logic [1:0]    numeric_count_next;
  logic          in_token;
  logic          in_token_next;
  tag_t          tag;
  logic          start;
  logic          over;
  logic [CW-1:0] sat_count;
  logic [IW-1:0] idx_wide;
  out_item_t     result_next;

  assign tok_take = tok_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      middle_count  <= '0;
      numeric_count <= '0;
      in_token      <= 1'b0;
    end else if (tok_take) begin
      phase         <= phase_next;
      middle_count  <= middle_count_next;
      numeric_count <= numeric_count_next;
      in_token      <= in_token_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    middle_count_next  = middle_count;
    numeric_count_next = numeric_count;
    in_token_next      = in_token;
    tag                = TAG_SKIP;
    start              = 1'b0;

    unique case (phase)
      PH_START: begin
        if (tok.cls == CLS_COLON) begin
          tag           = TAG_SEP;
          start         = 1'b1;
          phase_next    = PH_NAME;
          in_token_next = 1'b0;
        end else begin
          tag                = TAG_COMMAND;
          start              = 1'b1;
          phase_next         = PH_COMMAND;
          numeric_count_next = (tok.cls == CLS_LETTER) ? 2'd0 : 2'd1;
        end
      end
      PH_NAME: begin
        priority case (tok.cls)
          CLS_SPACE: begin
            phase_next    = PH_PRESP;
            in_token_next = 1'b0;
          end
          CLS_BANG: begin
            tag           = TAG_SEP;
            start         = 1'b1;
            phase_next    = PH_USER;
            in_token_next = 1'b0;
          end
          CLS_AT: begin
            tag           = TAG_SEP;
            start         = 1'b1;
            phase_next    = PH_HOST;
            in_token_next = 1'b0;
          end
          default: begin
            tag           = TAG_NAME;
            start         = !in_token;
            in_token_next = 1'b1;
          end
        endcase
      end
      PH_USER: begin
        priority case (tok.cls)
          CLS_SPACE: begin
            phase_next    = PH_PRESP;
            in_token_next = 1'b0;
          end
          CLS_AT: begin
            tag           = TAG_SEP;
            start         = 1'b1;
            phase_next    = PH_HOST;
            in_token_next = 1'b0;
          end
          default: begin
            tag           = TAG_USER;
            start         = !in_token;
            in_token_next = 1'b1;
          end
        endcase
      end
      PH_HOST: begin
        if (tok.cls == CLS_SPACE) begin
          phase_next    = PH_PRESP;
          in_token_next = 1'b0;
        end else begin
          tag           = TAG_HOST;
          start         = !in_token;
          in_token_next = 1'b1;
        end
      end
      PH_PRESP: begin
        if (tok.cls != CLS_SPACE) begin
          tag                = TAG_COMMAND;
          start              = 1'b1;
          phase_next         = PH_COMMAND;
          numeric_count_next = (tok.cls == CLS_LETTER) ? 2'd0 : 2'd1;
        end
      end
      PH_COMMAND: begin
        if (numeric_count == 2'd0) begin
          if (tok.cls == CLS_SPACE) begin
            phase_next = PH_PARAMS;
          end else begin
            tag = TAG_COMMAND;
          end
        end else begin
          tag = TAG_COMMAND;
          if (numeric_count == CMD_NUM_LAST) begin
            numeric_count_next = 2'd0;
            phase_next         = PH_PARAMS;
          end else begin
            numeric_count_next = numeric_count + 2'd1;
          end
        end
      end
      PH_PARAMS: begin
        if (in_token) begin
          if (tok.cls == CLS_SPACE) begin
            in_token_next = 1'b0;
          end else begin
            tag = TAG_MIDDLE;
          end
        end else if (tok.cls == CLS_COLON) begin
          tag        = TAG_TRAIL;
          start      = 1'b1;
          phase_next = PH_TRAIL;
        end else if (tok.cls != CLS_SPACE) begin
          if (middle_count <= MAX_C) begin
            middle_count_next = middle_count + CW'(1);
          end
          tag           = TAG_MIDDLE;
          start         = 1'b1;
          in_token_next = 1'b1;
        end
      end
      PH_TRAIL: begin
        tag = TAG_TRAIL;
      end
    endcase

    over      = (middle_count_next > MAX_C);
    sat_count = over ? MAX_C : middle_count_next;
    idx_wide  = IW'(sat_count) - IW'(1);

    result_next.out_byte        = tok.data_byte;
    result_next.field_tag       = tag;
    result_next.field_start     = start;
    result_next.middle_index    = ((tag == TAG_MIDDLE) && (middle_count_next != '0)) ?
                                  idx_wide[3:0] : 4'd0;
    result_next.too_many_params = over;
    result_next.end_of_message  = tok.last_byte;

    // Return to the start of a message after its final octet.
    if (tok.last_byte) begin
      phase_next         = PH_START;
      middle_count_next  = '0;
      numeric_count_next = 2'd0;
      in_token_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tok_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take) begin
      result <= result_next;
    end
  end

endmodule

[rtl/core/irc_tok_checker.sv]
`include "irc_message_tokenizer_assert.svh"

module irc_tok_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   result_valid,
  input logic                   result_ready,
  input irc_tok_pkg::out_item_t result
);
  import irc_tok_pkg::*;

  logic mid_take;
  logic over_take;
  logic over_kept;
  logic trail_take;
  logic trail_kept;

  assign mid_take   = result_valid && result_ready && !result.end_of_message;
  assign over_take  = mid_take && result.too_many_params;
  assign over_kept  = !result_valid || result.too_many_params;
  assign trail_take = mid_take && (result.field_tag == TAG_TRAIL);
  assign trail_kept = !result_valid || (result.field_tag == TAG_TRAIL);

  `IRC_TOK_HOLD(a_result_hold, result_valid, result_ready, result, "result dropped while stalled")

  `IRC_TOK_ASSERT(a_reset_empty, $past(rst) |-> !result_valid, "result valid right after reset")

  `IRC_TOK_ASSERT(a_over_sticky, over_take |=> over_kept, "overflow cleared inside a message")

  `IRC_TOK_ASSERT(a_trail_sticky, trail_take |=> trail_kept, "trailing part left before the end")

endmodule

bind irc_message_tokenizer irc_tok_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
